@@ rtl/hkrb_pkg.sv @@
// Shared types and constants for the boot-keyboard report builder.
package hkrb_pkg;

	typedef enum logic [1:0] {
		FUNC_PRESS   = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_CLEAR   = 2'd2,
		FUNC_SEND    = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		REG_MODIFIER_BASE = 1'b0
	} reg_idx_t;

	localparam logic [7:0] USAGE_NONE          = 8'h00;
	localparam logic [7:0] USAGE_INVALID       = 8'hFF;
	localparam logic [7:0] MODIFIER_BASE_RESET = 8'hE0;
	localparam logic [8:0] MODIFIER_SPAN       = 9'd7;
	localparam logic [2:0] KEY_COUNT_MAX       = 3'd7;
	localparam int         OUT_SLOTS           = 6;

	typedef struct packed {
		func_t       func;
		logic [15:0] key_code;
		logic        host_ready;
	} in_word_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] slot_0;
		logic [7:0] slot_1;
		logic [7:0] slot_2;
		logic [7:0] slot_3;
		logic [7:0] slot_4;
		logic [7:0] slot_5;
		logic       report_sent;
		logic [2:0] key_count;
		logic       key_held;
	} out_word_t;

endpackage

@@ rtl/hkrb_cfg.sv @@
// APB register block holding the modifier base code.
module hkrb_cfg import hkrb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  modifier_base
);

	logic [7:0] base_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= MODIFIER_BASE_RESET;
		end else if (wr_en && (reg_idx_t'(paddr[2]) == REG_MODIFIER_BASE)) begin
			base_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (reg_idx_t'(paddr[2]) == REG_MODIFIER_BASE) begin
			prdata = {24'd0, base_q};
		end
	end

	assign modifier_base = base_q;

endmodule

@@ rtl/hkrb_update.sv @@
// Next-state and result logic for one key event.
module hkrb_update import hkrb_pkg::*; #(
	parameter int SLOT_COUNT = 6
) (
	input  in_word_t   item,
	input  logic [7:0] modifier_base,
	input  logic [7:0] slots [SLOT_COUNT],
	input  logic [7:0] modifier,
	input  logic       changed,
	output logic [7:0] slots_nx [SLOT_COUNT],
	output logic [7:0] modifier_nx,
	output logic       changed_nx,
	output out_word_t  result
);

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	logic [7:0]       usage;
	logic             usable;
	logic             is_mod;
	logic [8:0]       mod_top;
	logic [7:0]       mod_bit;
	logic             any_match;
	logic             free_seen;
	logic             hit_seen;
	logic [7:0]       shift_src [SLOT_COUNT];
	logic [7:0]       press_slots [SLOT_COUNT];
	logic [7:0]       rel_slots [SLOT_COUNT];
	logic [CNT_W-1:0] cnt;
	logic [7:0]       out_slots [OUT_SLOTS];
	logic             sent;

	assign usage   = item.key_code[7:0];
	assign usable  = (item.key_code[15:8] == 8'd0) && (usage != USAGE_NONE)
		&& (usage != USAGE_INVALID);
	assign mod_top = {1'b0, modifier_base} + MODIFIER_SPAN;
	// full-width range test, no wrap past 255
	assign is_mod  = (item.key_code >= {8'd0, modifier_base})
		&& (item.key_code <= {7'd0, mod_top});
	assign mod_bit = 8'd1 << (item.key_code[2:0] - modifier_base[2:0]);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT - 1; i++) begin
			shift_src[i] = slots[i + 1];
		end
		shift_src[SLOT_COUNT - 1] = USAGE_NONE;
	end

	// first free slot for press, first hit and shift-down for release
	always_comb begin
		any_match = 1'b0;
		free_seen = 1'b0;
		hit_seen  = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			press_slots[i] = slots[i];
			if (!free_seen && (slots[i] == USAGE_NONE)) begin
				press_slots[i] = usage;
				free_seen      = 1'b1;
			end
			hit_seen     = hit_seen | (slots[i] == usage);
			rel_slots[i] = hit_seen ? shift_src[i] : slots[i];
		end
		any_match = hit_seen;
	end

	always_comb begin
		slots_nx    = slots;
		modifier_nx = modifier;
		changed_nx  = changed;
		sent        = 1'b0;
		unique case (item.func)
			FUNC_PRESS, FUNC_RELEASE: begin
				if (is_mod) begin
					modifier_nx = (item.func == FUNC_PRESS) ? (modifier | mod_bit)
						: (modifier & ~mod_bit);
					changed_nx  = 1'b1;
				end else if (usable) begin
					if (item.func == FUNC_PRESS) begin
						if (!any_match && free_seen) begin
							slots_nx   = press_slots;
							changed_nx = 1'b1;
						end
					end else if (any_match) begin
						slots_nx   = rel_slots;
						changed_nx = 1'b1;
					end
				end
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					slots_nx[i] = USAGE_NONE;
				end
				modifier_nx = 8'd0;
				changed_nx  = 1'b1;
			end
			FUNC_SEND: begin
				if (changed && item.host_ready) begin
					sent       = 1'b1;
					changed_nx = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			cnt = cnt + CNT_W'(slots_nx[i] != USAGE_NONE);
		end
		for (int i = 0; i < OUT_SLOTS; i++) begin
			out_slots[i] = USAGE_NONE;
		end
		for (int i = 0; i < OUT_SLOTS && i < SLOT_COUNT; i++) begin
			out_slots[i] = slots_nx[i];
		end
	end

	always_comb begin
		result.modifier_bits = modifier_nx;
		result.slot_0        = out_slots[0];
		result.slot_1        = out_slots[1];
		result.slot_2        = out_slots[2];
		result.slot_3        = out_slots[3];
		result.slot_4        = out_slots[4];
		result.slot_5        = out_slots[5];
		result.report_sent   = sent;
		result.key_count     = (32'(cnt) > 32'(KEY_COUNT_MAX)) ? KEY_COUNT_MAX : 3'(cnt);
		result.key_held      = ((item.func == FUNC_PRESS) || (item.func == FUNC_RELEASE))
			&& usable && any_match;
	end

endmodule

@@ rtl/hid_keyboard_report_builder.sv @@
// Top level: input register, report state, result register and config port.
//
//  channel | direction | handshake          | word
//  in      | sink      | in_valid/in_ready  | in_data  (func, key_code, host_ready)
//  out     | source    | out_valid/out_ready| out_data (modifiers, slots, flags)
//  apb     | slave     | psel/penable       | modifier_base at address 0
//
// One word per cycle while out_ready allows; it is held in item_s1, then in out_q.
// The report state is updated in the same cycle the result register loads.
// Reset clears the slots, modifiers, changed flag and sets modifier_base to 0xE0.
// A stalled output holds the input register; in_ready drops only when both are full.
module hid_keyboard_report_builder import hkrb_pkg::*; #(
	parameter int SLOT_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	in_word_t   item_s1;
	logic       valid_s1;
	logic [7:0] slots_q [SLOT_COUNT];
	logic [7:0] modifier_q;
	logic       changed_q;
	out_word_t  out_q;
	logic       out_valid_q;

	logic [7:0] modifier_base;
	logic [7:0] slots_nx [SLOT_COUNT];
	logic [7:0] modifier_nx;
	logic       changed_nx;
	out_word_t  result;
	logic       advance;
	logic       take;

	hkrb_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.modifier_base (modifier_base)
	);

	hkrb_update #(.SLOT_COUNT(SLOT_COUNT)) u_update (
		.item          (item_s1),
		.modifier_base (modifier_base),
		.slots         (slots_q),
		.modifier      (modifier_q),
		.changed       (changed_q),
		.slots_nx      (slots_nx),
		.modifier_nx   (modifier_nx),
		.changed_nx    (changed_nx),
		.result        (result)
	);

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= USAGE_NONE;
			end
			modifier_q  <= 8'd0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				slots_q     <= slots_nx;
				modifier_q  <= modifier_nx;
				changed_q   <= changed_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word did not reach the result register");

	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(modifier_q) && $stable(changed_q))
		else $error("report state changed without a processed word");

	a_send_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.func == FUNC_SEND) && !changed_q |=> !out_q.report_sent)
		else $error("report sent with nothing changed");

	a_sent_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.func == FUNC_SEND) && changed_q && item_s1.host_ready
		|=> out_q.report_sent && !changed_q)
		else $error("send with change and ready host did not deliver");

endmodule
